// ----- design/atrp_pkg.sv -----
// Package with the types, character codes and limits of the modem reply parser.
`timescale 1ns / 1ps

package atrp_pkg;

    // Reply limits.
    localparam int unsigned MAX_LINES  = 1024;
    localparam int unsigned LINE_CHARS = 127;

    // Field and counter widths.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned LIDX_W  = 10;
    localparam int unsigned COL_W   = 7;
    localparam int unsigned LINES_W = 11;

    // Character codes.
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
    localparam logic [BYTE_W-1:0] CH_K     = 8'h4B;
    localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
    localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;

    // Reply status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_PENDING   = 2'd0,
        ST_COMPLETE  = 2'd1,
        ST_MALFORMED = 2'd2
    } status_t;

    // Final text kind.
    typedef enum logic {
        KIND_OK    = 1'b0,
        KIND_ERROR = 1'b1
    } kind_t;

    // Parser phases.
    typedef enum logic [4:0] {
        PH_IDLE, PH_OPEN_LF, PH_FIRST, PH_O, PH_OK_CR, PH_OK_LF,
        PH_E, PH_ER, PH_ERR, PH_ERRO, PH_ERROR_CR, PH_ERROR_LF,
        PH_PLUS, PH_TEXT, PH_LINE_LF, PH_AFTER_LINE, PH_BLANK_LF, PH_FINAL
    } phase_t;

endpackage

// ----- design/at_response_parser.sv -----
// Top level of the modem reply parser: phase machine, counters and result register.
// A result word is registered and appears in the cycle after its input byte is accepted.
// Throughput: one byte per cycle unless stalled; the phase machine and both counters update together.
// A new byte enters in the same cycle that the previous result is taken; a stalled result
// stalls the input.
// Reset (rst_n low, asynchronous) returns the parser to idle, clears both counters and
// empties the result register.
`timescale 1ns / 1ps

module at_response_parser
    import atrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [STAT_W-1:0] status,
    output logic              reply_kind,
    output logic              char_valid,
    output logic [BYTE_W-1:0] payload_char,
    output logic [LIDX_W-1:0] line_index,
    output logic [COL_W-1:0]  column,
    output logic [LINES_W-1:0] line_total
);

    localparam logic [LINES_W-1:0] MAX_LINES_C  = LINES_W'(MAX_LINES);
    localparam logic [COL_W-1:0]   LINE_CHARS_C = COL_W'(LINE_CHARS);

    phase_t              phase_reg, phase_next;
    logic [LINES_W-1:0]  lines_reg, lines_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    kind_t               kind_reg, kind_next;
    logic                cvalid_reg, cvalid_next;
    logic [BYTE_W-1:0]   pchar_reg, pchar_next;
    logic [LIDX_W-1:0]   lidx_reg, lidx_next;
    logic [COL_W-1:0]    colout_reg, colout_next;
    logic [LINES_W-1:0]  total_reg, total_next;

    logic accept;
    logic bad;
    logic printable;
    logic done;

    // Handshake: the result register holds until taken.
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign printable = (rx_byte >= CH_SPACE) && (rx_byte < CH_DEL);

    // Next phase and error detection.
    always_comb
    begin
        phase_next = phase_reg;
        bad        = 1'b0;
        done       = 1'b0;
        unique case (phase_reg) inside
            PH_IDLE:
            begin
                if (rx_byte == CH_CR) phase_next = PH_OPEN_LF;
            end
            PH_OPEN_LF:
            begin
                if (rx_byte == CH_LF) phase_next = PH_FIRST; else bad = 1'b1;
            end
            PH_FIRST, PH_AFTER_LINE:
            begin
                if (phase_reg == PH_FIRST && rx_byte == CH_O) phase_next = PH_O;
                else if (phase_reg == PH_FIRST && rx_byte == CH_E) phase_next = PH_E;
                else if (phase_reg == PH_AFTER_LINE && rx_byte == CH_CR)
                    phase_next = PH_BLANK_LF;
                else if (rx_byte == CH_PLUS && lines_reg < MAX_LINES_C) phase_next = PH_PLUS;
                else bad = 1'b1;
            end
            PH_O:
            begin
                if (rx_byte == CH_K) phase_next = PH_OK_CR; else bad = 1'b1;
            end
            PH_OK_CR:
            begin
                if (rx_byte == CH_CR) phase_next = PH_OK_LF; else bad = 1'b1;
            end
            PH_E:
            begin
                if (rx_byte == CH_R) phase_next = PH_ER; else bad = 1'b1;
            end
            PH_ER:
            begin
                if (rx_byte == CH_R) phase_next = PH_ERR; else bad = 1'b1;
            end
            PH_ERR:
            begin
                if (rx_byte == CH_O) phase_next = PH_ERRO; else bad = 1'b1;
            end
            PH_ERRO:
            begin
                if (rx_byte == CH_R) phase_next = PH_ERROR_CR; else bad = 1'b1;
            end
            PH_ERROR_CR:
            begin
                if (rx_byte == CH_CR) phase_next = PH_ERROR_LF; else bad = 1'b1;
            end
            PH_OK_LF, PH_ERROR_LF:
            begin
                if (rx_byte == CH_LF)
                begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
                else bad = 1'b1;
            end
            PH_PLUS, PH_TEXT:
            begin
                if (phase_reg == PH_TEXT && rx_byte == CH_CR) phase_next = PH_LINE_LF;
                else if (printable && col_reg < LINE_CHARS_C) phase_next = PH_TEXT;
                else bad = 1'b1;
            end
            PH_LINE_LF:
            begin
                if (rx_byte == CH_LF) phase_next = PH_AFTER_LINE; else bad = 1'b1;
            end
            PH_BLANK_LF:
            begin
                if (rx_byte == CH_LF) phase_next = PH_FINAL; else bad = 1'b1;
            end
            PH_FINAL:
            begin
                if (rx_byte == CH_O) phase_next = PH_O;
                else if (rx_byte == CH_E) phase_next = PH_E;
                else bad = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        if (bad) phase_next = PH_IDLE;
    end

    // Counters and result fields.
    always_comb
    begin
        lines_next  = lines_reg;
        col_next    = col_reg;
        status_next = ST_PENDING;
        kind_next   = KIND_OK;
        cvalid_next = 1'b0;
        pchar_next  = '0;
        lidx_next   = '0;
        colout_next = '0;
        total_next  = '0;
        if (bad)
        begin
            status_next = ST_MALFORMED;
            lines_next  = '0;
            col_next    = '0;
        end
        else if (done)
        begin
            status_next = ST_COMPLETE;
            kind_next   = (phase_reg == PH_ERROR_LF) ? KIND_ERROR : KIND_OK;
            total_next  = lines_reg;
            lines_next  = '0;
            col_next    = '0;
        end
        else if (phase_next == PH_PLUS)
        begin
            // A new '+' line begins.
            lines_next = lines_reg + LINES_W'(1);
            col_next   = '0;
        end
        else if (phase_next == PH_TEXT)
        begin
            // Captured payload character.
            cvalid_next = 1'b1;
            pchar_next  = rx_byte;
            lidx_next   = LIDX_W'(lines_reg - LINES_W'(1));
            colout_next = col_reg;
            col_next    = col_reg + COL_W'(1);
        end
        else if (phase_reg > PH_ERROR_LF || phase_reg == PH_IDLE)
        begin
            // Unknown phase codes fall back to idle with clear counters, and idle keeps them clear.
            if (phase_next == PH_IDLE)
            begin
                lines_next = '0;
                col_next   = '0;
            end
        end
    end

    // Result register occupancy.
    always_comb
    begin
        if (accept) out_valid_next = 1'b1;
        else if (!out_stall) out_valid_next = 1'b0;
        else out_valid_next = out_valid_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            lines_reg     <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                lines_reg <= lines_next;
                col_reg   <= col_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            kind_reg   <= kind_next;
            cvalid_reg <= cvalid_next;
            pchar_reg  <= pchar_next;
            lidx_reg   <= lidx_next;
            colout_reg <= colout_next;
            total_reg  <= total_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign reply_kind   = kind_reg;
    assign char_valid   = cvalid_reg;
    assign payload_char = pchar_reg;
    assign line_index   = lidx_reg;
    assign column       = colout_reg;
    assign line_total   = total_reg;

endmodule

// ----- verif/tb_at_response_parser.sv -----
// Testbench for the modem reply parser: byte stimulus, reply prediction and result checking.
`timescale 1ns / 1ps

import atrp_pkg::*;

// One result word as the parser should present it.
typedef struct packed {
    status_t             status;
    kind_t               kind;
    logic                cvalid;
    logic [BYTE_W-1:0]   pchar;
    logic [LIDX_W-1:0]   lidx;
    logic [COL_W-1:0]    col;
    logic [LINES_W-1:0]  total;
} reply_word_t;

// Tracks the reply grammar byte by byte and holds the result words still to come.
class reply_checker;
    phase_t             phase;
    logic [LINES_W-1:0] lines_begun;
    logic [COL_W-1:0]   chars_in_line;
    reply_word_t        expected_words[$];
    int                 errors;

    function new();
        errors = 0;
        go_idle();
    endfunction

    function void go_idle();
        phase = PH_IDLE;
        lines_begun = '0;
        chars_in_line = '0;
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    // Advance the grammar by one accepted byte and queue the word it causes.
    function void take_byte(logic [BYTE_W-1:0] c);
        reply_word_t w;
        bit          bad;
        w = '0;
        bad = 1'b0;
        case (phase)
            PH_IDLE: if (c == CH_CR) phase = PH_OPEN_LF;
            PH_OPEN_LF: if (c == CH_LF) phase = PH_FIRST; else bad = 1'b1;
            PH_FIRST, PH_AFTER_LINE:
            begin
                if (phase == PH_FIRST && c == CH_O) phase = PH_O;
                else if (phase == PH_FIRST && c == CH_E) phase = PH_E;
                else if (phase == PH_AFTER_LINE && c == CH_CR) phase = PH_BLANK_LF;
                else if (c == CH_PLUS)
                begin
                    if (lines_begun >= MAX_LINES)
                        bad = 1'b1;
                    else
                    begin
                        lines_begun = lines_begun + 1'b1;
                        chars_in_line = '0;
                        phase = PH_PLUS;
                    end
                end
                else bad = 1'b1;
            end
            PH_O: if (c == CH_K) phase = PH_OK_CR; else bad = 1'b1;
            PH_OK_CR: if (c == CH_CR) phase = PH_OK_LF; else bad = 1'b1;
            PH_E: if (c == CH_R) phase = PH_ER; else bad = 1'b1;
            PH_ER: if (c == CH_R) phase = PH_ERR; else bad = 1'b1;
            PH_ERR: if (c == CH_O) phase = PH_ERRO; else bad = 1'b1;
            PH_ERRO: if (c == CH_R) phase = PH_ERROR_CR; else bad = 1'b1;
            PH_ERROR_CR: if (c == CH_CR) phase = PH_ERROR_LF; else bad = 1'b1;
            PH_OK_LF, PH_ERROR_LF:
            begin
                if (c == CH_LF)
                begin
                    w.status = ST_COMPLETE;
                    if (phase == PH_ERROR_LF) w.kind = KIND_ERROR;
                    else w.kind = KIND_OK;
                    w.total = lines_begun;
                    go_idle();
                end
                else bad = 1'b1;
            end
            PH_PLUS, PH_TEXT:
            begin
                if (phase == PH_TEXT && c == CH_CR) phase = PH_LINE_LF;
                else if (c >= CH_SPACE && c < CH_DEL)
                begin
                    if (chars_in_line >= LINE_CHARS)
                        bad = 1'b1;
                    else
                    begin
                        w.cvalid = 1'b1;
                        w.pchar = c;
                        w.lidx = LIDX_W'(lines_begun - 1'b1);
                        w.col = chars_in_line;
                        chars_in_line = chars_in_line + 1'b1;
                        phase = PH_TEXT;
                    end
                end
                else bad = 1'b1;
            end
            PH_LINE_LF: if (c == CH_LF) phase = PH_AFTER_LINE; else bad = 1'b1;
            PH_BLANK_LF: if (c == CH_LF) phase = PH_FINAL; else bad = 1'b1;
            PH_FINAL:
            begin
                if (c == CH_O) phase = PH_O;
                else if (c == CH_E) phase = PH_E;
                else bad = 1'b1;
            end
            default: go_idle();
        endcase
        // A malformed reply drops the parser back to idle; this byte does not restart it.
        if (bad)
        begin
            w.status = ST_MALFORMED;
            go_idle();
        end
        expected_words.push_back(w);
    endfunction

    function void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            errors++;
        end
    endfunction

    // Compare one accepted result word with the oldest expected word.
    function void check_word(reply_word_t got);
        reply_word_t want;
        if (expected_words.size() == 0)
        begin
            $error("result word with no expected word waiting");
            errors++;
            return;
        end
        want = expected_words.pop_front();
        check_field("status", want.status, got.status);
        check_field("reply_kind", want.kind, got.kind);
        check_field("char_valid", want.cvalid, got.cvalid);
        check_field("payload_char", want.pchar, got.pchar);
        check_field("line_index", want.lidx, got.lidx);
        check_field("column", want.col, got.col);
        check_field("line_total", want.total, got.total);
    endfunction
endclass

module tb_at_response_parser;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 750;
    localparam int DRAIN_CYCLES   = 8;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [BYTE_W-1:0]  rx_byte;
    logic               out_valid;
    logic               out_stall;
    logic [STAT_W-1:0]  status;
    logic               reply_kind;
    logic               char_valid;
    logic [BYTE_W-1:0]  payload_char;
    logic [LIDX_W-1:0]  line_index;
    logic [COL_W-1:0]   column;
    logic [LINES_W-1:0] line_total;

    reply_checker       chk = new();
    int                 gap_pct = 0;
    int                 stall_pct = 0;
    int                 quiet_cycles = 0;
    int                 random_items = 0;
    logic [BYTE_W-1:0]  burst[$];

    at_response_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .reply_kind   (reply_kind),
        .char_valid   (char_valid),
        .payload_char (payload_char),
        .line_index   (line_index),
        .column       (column),
        .line_total   (line_total)
    );

    always #4 clk = ~clk;

    // Receiver back-pressure at the current stall rate.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watch both handshakes, feed the predictor and check results; stop a hung run.
    always @(posedge clk)
    begin
        reply_word_t got;
        if (rst_n)
        begin
            quiet_cycles++;
            if (in_valid && !in_stall)
            begin
                chk.take_byte(rx_byte);
                quiet_cycles = 0;
            end
            if (out_valid && !out_stall)
            begin
                got.status = status_t'(status);
                got.kind = kind_t'(reply_kind);
                got.cvalid = char_valid;
                got.pchar = payload_char;
                got.lidx = line_index;
                got.col = column;
                got.total = line_total;
                chk.check_word(got);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL at_response_parser");
                $finish;
            end
        end
    end

    // Present one byte and hold it until the parser takes it.
    task send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (in_stall !== 1'b0);
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task send_crlf();
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // Stop sending until every expected word has come back.
    task drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (chk.pending() != 0);
    endtask

    task set_idling(input int gap, input int stall);
        gap_pct = gap;
        stall_pct = stall;
    endtask

    function void push_crlf();
        burst.push_back(CH_CR);
        burst.push_back(CH_LF);
    endfunction

    // Build one random reply, mostly well formed, sometimes damaged or cut short.
    task send_random_reply();
        int noise_len;
        int n_lines;
        int len;
        int pos;
        burst.delete();
        noise_len = $urandom_range(0, 2);
        repeat (noise_len) burst.push_back(BYTE_W'($urandom_range(255)));
        push_crlf();
        n_lines = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
        repeat (n_lines)
        begin
            burst.push_back(CH_PLUS);
            len = ($urandom_range(19) == 0) ? LINE_CHARS : $urandom_range(1, 12);
            repeat (len) burst.push_back(BYTE_W'($urandom_range(32, 126)));
            push_crlf();
        end
        if (n_lines > 0) push_crlf();
        if ($urandom_range(1))
        begin
            burst.push_back(CH_O);
            burst.push_back(CH_K);
        end
        else
        begin
            burst.push_back(CH_E);
            burst.push_back(CH_R);
            burst.push_back(CH_R);
            burst.push_back(CH_O);
            burst.push_back(CH_R);
        end
        push_crlf();
        // Damage about one reply in four with a random byte, and cut some of those short.
        if ($urandom_range(3) == 0)
        begin
            pos = $urandom_range(noise_len, burst.size() - 1);
            burst[pos] = BYTE_W'($urandom_range(255));
            if ($urandom_range(1))
                burst = burst[0:pos];
        end
        foreach (burst[i])
            send_byte(burst[i]);
        random_items += burst.size();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        rx_byte <= '0;
        out_stall <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed replies: idle noise, plain OK, ERROR with an extreme-character line,
        // an unexpected letter and a CR where LF belongs.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_crlf();
        send_text("OK");
        send_crlf();
        send_crlf();
        send_text("+ ~");
        send_crlf();
        send_crlf();
        send_text("ERROR");
        send_crlf();
        send_crlf();
        send_text("X");
        send_byte(CH_CR);
        send_byte(CH_CR);
        drain();

        // Overlong line: a full line of text and then one character too many.
        send_crlf();
        send_byte(CH_PLUS);
        repeat (LINE_CHARS) send_byte(BYTE_W'($urandom_range(32, 126)));
        send_byte(BYTE_W'($urandom_range(32, 126)));
        drain();

        // Random replies in four idling phases, each followed by a full drain.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_idling(0, 0);
                1: set_idling(60, 0);
                2: set_idling(0, 60);
                default: set_idling(38, 38);
            endcase
            while (random_items < (ph + 1) * RANDOM_ITEMS / 4)
                send_random_reply();
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (chk.errors == 0 && chk.pending() == 0)
            $display("PASS at_response_parser");
        else
            $display("FAIL at_response_parser");
        $finish;
    end

endmodule

// ----- at_response_parser.f -----
design/atrp_pkg.sv
design/at_response_parser.sv
verif/tb_at_response_parser.sv
